// ===== src/mer_pkg.sv =====
package mer_pkg;

   // datapath commands, one per cycle
   typedef enum logic [3:0] {
      CMD_NOP,
      CMD_LOAD,
      CMD_SQ_RX,
      CMD_SQ_RY,
      CMD_MUL_RY,
      CMD_INIT,
      CMD_SW_TX,
      CMD_SW_A,
      CMD_SW_TY,
      CMD_SW_B,
      CMD_SW_C,
      CMD_SW_D,
      CMD_STEP1,
      CMD_STEP2
   } dp_cmd_type;

   typedef struct packed {
      dp_cmd_type cmd;
   } ctl_cmd_type;

   typedef struct packed {
      logic r1_go;   // x slope term below y slope term
      logic y_zero;  // vertical offset reached zero
   } dp_status_type;

   localparam logic REQ_START   = 1'b0;
   localparam logic REQ_ADVANCE = 1'b1;

endpackage

// ===== src/mer_datapath.sv =====
module mer_datapath
   import mer_pkg::*;
#(
   parameter int COORD_BITS  = 12,
   parameter int RADIUS_BITS = 11
) (
   input  logic                    clock,
   input  ctl_cmd_type             ctl,
   input  logic [COORD_BITS-1:0]   center_x,
   input  logic [COORD_BITS-1:0]   center_y,
   input  logic [RADIUS_BITS-1:0]  radius_x,
   input  logic [RADIUS_BITS-1:0]  radius_y,
   output dp_status_type           status,
   output logic [COORD_BITS+1:0]   right_x,
   output logic [COORD_BITS+1:0]   left_x,
   output logic [COORD_BITS+1:0]   upper_y,
   output logic [COORD_BITS+1:0]   lower_y
);

   localparam int R   = RADIUS_BITS;
   localparam int C   = COORD_BITS;
   localparam int OFW = R + 2;
   localparam int MW  = 2 * R + 6;
   localparam int SW  = 3 * R + 5;
   localparam int DW  = 4 * R + 8;
   localparam int PW  = C + 2;
   localparam int WW  = C + R + 4;

   logic [C-1:0]          cx_ff, cy_ff, cx_in, cy_in;
   logic [R-1:0]          rx_ff, ry_ff, rx_in, ry_in;
   logic [OFW-1:0]        x_ff, y_ff, x_in, y_in;
   logic [2*R-1:0]        rx2_ff, ry2_ff, rx2_in, ry2_in;
   logic signed [SW-1:0]  sx_ff, sy_ff, sx_in, sy_in;
   logic signed [DW-1:0]  dec_ff, dec_in, acc_ff, acc_in;
   logic [2*MW-1:0]       prod_ff, prod_in;
   logic [MW-1:0]         mul_a, mul_b;

   logic signed [SW-1:0]  sx_step, sy_step;
   logic signed [DW-1:0]  rx2_d, ry2_d, prod_d, sx_step_d, sy_step_d;
   logic [OFW:0]          tx;
   logic [OFW-1:0]        ty;

   // widened views of the stored terms
   assign rx2_d     = $signed(DW'(rx2_ff));
   assign ry2_d     = $signed(DW'(ry2_ff));
   assign prod_d    = $signed(prod_ff[DW-1:0]);
   assign sx_step   = sx_ff + $signed(SW'({ry2_ff, 1'b0}));
   assign sy_step   = sy_ff - $signed(SW'({rx2_ff, 1'b0}));
   assign sx_step_d = DW'(sx_step);
   assign sy_step_d = DW'(sy_step);
   assign tx        = {x_ff, 1'b1};
   assign ty        = y_ff - OFW'(1);

   // select multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (ctl.cmd)
         CMD_SQ_RX: begin
            mul_a = MW'(rx_ff);
            mul_b = MW'(rx_ff);
         end
         CMD_SQ_RY: begin
            mul_a = MW'(ry_ff);
            mul_b = MW'(ry_ff);
         end
         CMD_MUL_RY: begin
            mul_a = MW'(rx2_ff);
            mul_b = MW'(ry_ff);
         end
         CMD_SW_TX: begin
            mul_a = MW'(tx);
            mul_b = MW'(tx);
         end
         CMD_SW_A: begin
            mul_a = MW'(ry2_ff);
            mul_b = prod_ff[MW-1:0];
         end
         CMD_SW_TY: begin
            mul_a = MW'(ty);
            mul_b = MW'(ty);
         end
         CMD_SW_B: begin
            mul_a = MW'(rx2_ff);
            mul_b = prod_ff[MW-1:0];
         end
         CMD_SW_C: begin
            mul_a = MW'(rx2_ff);
            mul_b = MW'(ry2_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // next-state values of the walk
   always_comb begin
      cx_in  = cx_ff;
      cy_in  = cy_ff;
      rx_in  = rx_ff;
      ry_in  = ry_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      rx2_in = rx2_ff;
      ry2_in = ry2_ff;
      sx_in  = sx_ff;
      sy_in  = sy_ff;
      dec_in = dec_ff;
      acc_in = acc_ff;
      unique case (ctl.cmd)
         CMD_LOAD: begin
            cx_in = center_x;
            cy_in = center_y;
            rx_in = radius_x;
            ry_in = radius_y;
            x_in  = '0;
            y_in  = OFW'(radius_y);
         end
         CMD_SQ_RY:  rx2_in = prod_ff[2*R-1:0];
         CMD_MUL_RY: ry2_in = prod_ff[2*R-1:0];
         CMD_INIT: begin
            sx_in  = '0;
            sy_in  = $signed(prod_ff[SW-2:0]) <<< 1;
            dec_in = ((ry2_d <<< 2) - (prod_d <<< 2) + rx2_d + DW'(2)) >>> 2;
         end
         CMD_SW_TY: acc_in = prod_d;
         CMD_SW_C:  acc_in = acc_ff + (prod_d <<< 2);
         CMD_SW_D:  dec_in = (acc_ff - (prod_d <<< 2) + DW'(2)) >>> 2;
         CMD_STEP1: begin
            x_in  = x_ff + OFW'(1);
            sx_in = sx_step;
            if (dec_ff < 0) begin
               dec_in = dec_ff + ry2_d + sx_step_d;
            end else begin
               y_in   = y_ff - OFW'(1);
               sy_in  = sy_step;
               dec_in = dec_ff + ry2_d + sx_step_d - sy_step_d;
            end
         end
         CMD_STEP2: begin
            y_in  = y_ff - OFW'(1);
            sy_in = sy_step;
            if (dec_ff > 0) begin
               dec_in = dec_ff + rx2_d - sy_step_d;
            end else begin
               x_in   = x_ff + OFW'(1);
               sx_in  = sx_step;
               dec_in = dec_ff + rx2_d - sy_step_d + sx_step_d;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      rx_ff   <= rx_in;
      ry_ff   <= ry_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      rx2_ff  <= rx2_in;
      ry2_ff  <= ry2_in;
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      dec_ff  <= dec_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   // status back to the controller
   assign status.r1_go  = (sx_ff < sy_ff);
   assign status.y_zero = (y_ff == '0);

   // four symmetric coordinates, wrapped to the output width
   logic [WW-1:0] cxw, cyw, xw, yw, rxs, lxs, uys, lys;
   assign cxw = WW'(cx_ff);
   assign cyw = WW'(cy_ff);
   assign xw  = WW'(x_ff);
   assign yw  = WW'(y_ff);
   assign rxs = cxw + xw;
   assign lxs = cxw - xw;
   assign uys = cyw + yw;
   assign lys = cyw - yw;
   assign right_x = rxs[PW-1:0];
   assign left_x  = lxs[PW-1:0];
   assign upper_y = uys[PW-1:0];
   assign lower_y = lys[PW-1:0];

endmodule

// ===== src/mer_controller.sv =====
module mer_controller
   import mer_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic          no_point,
   input  dp_status_type status,
   output ctl_cmd_type   ctl
);

   typedef enum logic [3:0] {
      ST_WAIT,
      ST_SQ_RX,
      ST_SQ_RY,
      ST_MUL_RY,
      ST_INIT,
      ST_SW_TX,
      ST_SW_A,
      ST_SW_TY,
      ST_SW_B,
      ST_SW_C,
      ST_SW_D,
      ST_STEP2,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_R1,
      PH_R2
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      nopt_ff, nopt_in;
   logic      req_fire, rsp_fire;

   assign req_tready = (state_ff == ST_WAIT);
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign no_point   = nopt_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   // sequence commands and next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      nopt_in  = nopt_ff;
      ctl.cmd  = CMD_NOP;
      unique case (state_ff)
         ST_WAIT: begin
            if (req_fire) begin
               nopt_in = 1'b0;
               priority if (req_tuser == REQ_START) begin
                  ctl.cmd  = CMD_LOAD;
                  phase_in = PH_R1;
                  state_in = ST_SQ_RX;
               end else if (phase_ff == PH_IDLE) begin
                  nopt_in  = 1'b1;
                  state_in = ST_EMIT;
               end else if (phase_ff == PH_R1 && status.r1_go) begin
                  ctl.cmd  = CMD_STEP1;
                  state_in = ST_EMIT;
               end else if (phase_ff == PH_R1) begin
                  phase_in = PH_R2;
                  state_in = ST_SW_TX;
               end else begin
                  ctl.cmd  = CMD_STEP2;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SQ_RX: begin
            ctl.cmd  = CMD_SQ_RX;
            state_in = ST_SQ_RY;
         end
         ST_SQ_RY: begin
            ctl.cmd  = CMD_SQ_RY;
            state_in = ST_MUL_RY;
         end
         ST_MUL_RY: begin
            ctl.cmd  = CMD_MUL_RY;
            state_in = ST_INIT;
         end
         ST_INIT: begin
            ctl.cmd  = CMD_INIT;
            state_in = ST_EMIT;
         end
         ST_SW_TX: begin
            ctl.cmd  = CMD_SW_TX;
            state_in = ST_SW_A;
         end
         ST_SW_A: begin
            ctl.cmd  = CMD_SW_A;
            state_in = ST_SW_TY;
         end
         ST_SW_TY: begin
            ctl.cmd  = CMD_SW_TY;
            state_in = ST_SW_B;
         end
         ST_SW_B: begin
            ctl.cmd  = CMD_SW_B;
            state_in = ST_SW_C;
         end
         ST_SW_C: begin
            ctl.cmd  = CMD_SW_C;
            state_in = ST_SW_D;
         end
         ST_SW_D: begin
            ctl.cmd  = CMD_SW_D;
            state_in = ST_STEP2;
         end
         ST_STEP2: begin
            ctl.cmd  = CMD_STEP2;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // hold the result until taken; drop to idle at the last point
            if (rsp_fire) begin
               state_in = ST_WAIT;
               if (!nopt_ff && status.y_zero) begin
                  phase_in = PH_IDLE;
               end
            end
         end
         default: state_in = ST_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WAIT;
         phase_ff <= PH_IDLE;
         nopt_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         nopt_ff  <= nopt_in;
      end
   end

endmodule

// ===== src/midpoint_ellipse_rasterizer.sv =====
// channel | dir | tdata (low bit up)                       | tuser    | tlast
// req     | in  | center_x, center_y, radius_x, radius_y   | req_type | -
// rsp     | out | right_x, left_x, upper_y, lower_y        | no_point | last_point
//
// One item in, one item out. A step in region 1 or region 2 presents its result
// the cycle after accept. A start first passes through SQ_RX, SQ_RY, MUL_RY and
// INIT (three products through the shared multiplier), the advance that switches
// regions through SW_TX, SW_A, SW_TY, SW_B, SW_C, SW_D and STEP2 (five products). The next item is taken
// the cycle after the previous result has been taken.
// Synchronous reset returns the block to idle; coordinates are not cleared.
module midpoint_ellipse_rasterizer
   import mer_pkg::*;
#(
   parameter int COORD_BITS  = 12,
   parameter int RADIUS_BITS = 11
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // center_x, center_y, radius_x, radius_y
   input  logic [((2*COORD_BITS+2*RADIUS_BITS+7)/8)*8-1:0] req_tdata,
   // req_type
   input  logic                req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // right_x, left_x, upper_y, lower_y
   output logic [((4*(COORD_BITS+2)+7)/8)*8-1:0] rsp_tdata,
   // no_point
   output logic                rsp_tuser,
   output logic                rsp_tlast
);

   localparam int C   = COORD_BITS;
   localparam int R   = RADIUS_BITS;
   localparam int PW  = C + 2;
   localparam int OTW = ((4 * PW + 7) / 8) * 8;

   ctl_cmd_type   ctl;
   dp_status_type status;
   logic          nopt;
   logic [PW-1:0] right_x, left_x, upper_y, lower_y;

   mer_controller u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .no_point   (nopt),
      .status     (status),
      .ctl        (ctl)
   );

   mer_datapath #(
      .COORD_BITS  (C),
      .RADIUS_BITS (R)
   ) u_dp (
      .clock    (clock),
      .ctl      (ctl),
      .center_x (req_tdata[C-1:0]),
      .center_y (req_tdata[2*C-1:C]),
      .radius_x (req_tdata[2*C+R-1:2*C]),
      .radius_y (req_tdata[2*C+2*R-1:2*C+R]),
      .status   (status),
      .right_x  (right_x),
      .left_x   (left_x),
      .upper_y  (upper_y),
      .lower_y  (lower_y)
   );

   // zero the coordinates of a no-point item
   assign rsp_tdata = nopt ? '0 : OTW'({lower_y, upper_y, left_x, right_x});
   assign rsp_tuser = nopt;
   assign rsp_tlast = !nopt && status.y_zero;

endmodule
